// ===== src/wms_pkg.sv =====
// Shared types, constants and helpers of the windowed mean / deviation block.
package wms_pkg;

  localparam int WINDOW_MAX_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // window register
  localparam int              CFG_W        = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd16;
  localparam int              WIN_REG_MAX  = 2**CFG_W - 1;

  // result fields
  localparam int MEAN_W      = 16;
  localparam int STD_W       = 16;
  localparam int FILL_W      = 7;
  localparam int OUT_TDATA_W = ((MEAN_W + STD_W + FILL_W + 7) / 8) * 8;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic             start;
    logic [CFG_W-1:0] win;
  } item_ctrl_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SQUARE,
    BK_UPDATE,
    BK_PROD_LO,
    BK_PROD_HI,
    BK_ROOT,
    BK_DIV_STD
  } back_state_e;

  // largest sample count the window can reach
  function automatic int cnt_max(input int window_max);
    return (window_max < WIN_REG_MAX) ? window_max : WIN_REG_MAX;
  endfunction

endpackage

// ===== src/wms_front.sv =====
// Front end: window register, window clamping and item tagging into the queue.
module wms_front #(
  parameter int WINDOW_MAX   = wms_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = wms_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [wms_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic                                 in_valid_i,
  input  logic [SAMPLE_WIDTH-1:0]              in_sample_i,
  input  logic                                 in_start_i,
  output logic                                 in_ready_o,
  input  logic                                 q_full_i,
  output logic                                 push_o,
  output logic [$bits(wms_pkg::item_ctrl_t)+SAMPLE_WIDTH-1:0] push_data_o
);

  localparam int CfgW   = wms_pkg::CFG_W;
  localparam int CntMax = wms_pkg::cnt_max(WINDOW_MAX);

  logic [CfgW-1:0]     window_q;
  logic [CfgW-1:0]     win_eff;
  wms_pkg::item_ctrl_t ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= wms_pkg::WINDOW_RESET;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  // zero acts as one, anything above the ring acts as the ring size
  always_comb begin
    if (window_q == '0) begin
      win_eff = CfgW'(1);
    end else if (window_q > CfgW'(CntMax)) begin
      win_eff = CfgW'(CntMax);
    end else begin
      win_eff = window_q;
    end
  end

  always_comb begin
    ctrl.start = in_start_i;
    ctrl.win   = win_eff;
  end

  assign in_ready_o  = !q_full_i;
  assign push_o      = in_valid_i && !q_full_i;
  assign push_data_o = {ctrl, in_sample_i};

endmodule

// ===== src/wms_fifo.sv =====
// Short item queue between front end and back end.
module wms_fifo #(
  parameter int DATA_W = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int Depth = wms_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [DATA_W-1:0] slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slot_q[rd_ptr_q];

endmodule

// ===== src/wms_div.sv =====
// Restoring divider, one quotient bit per cycle.
module wms_div #(
  parameter int DIVIDEND_W = 22,
  parameter int DIVISOR_W  = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  busy_o,
  output logic [DIVIDEND_W-1:0] quot_o
);

  localparam int StepW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic [StepW-1:0]      step_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q, dsr_q;
  logic [DIVISOR_W:0]    rem_s, rem_n;
  logic                  ge;

  // shift next dividend bit into the partial remainder
  always_comb begin
    rem_s = {rem_q, quo_q[DIVIDEND_W-1]};
    ge    = (rem_s >= {1'b0, dsr_q});
    rem_n = ge ? rem_s - {1'b0, dsr_q} : rem_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= StepW'(DIVIDEND_W);
    end else if (busy_q) begin
      step_q <= step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
      rem_q <= rem_n[DIVISOR_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

// ===== src/wms_back.sv =====
// Back end: sample ring, running sums, square root, shared divider, result register.
module wms_back #(
  parameter int WINDOW_MAX   = wms_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = wms_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  logic [$bits(wms_pkg::item_ctrl_t)+SAMPLE_WIDTH-1:0] q_data_i,
  output logic                                 q_pop_o,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output logic [wms_pkg::MEAN_W-1:0]           mean_o,
  output logic [wms_pkg::STD_W-1:0]            std_o,
  output logic [wms_pkg::FILL_W-1:0]           fill_o
);

  localparam int Sw     = SAMPLE_WIDTH;
  localparam int ItemW  = $bits(wms_pkg::item_ctrl_t) + Sw;
  localparam int CfgW   = wms_pkg::CFG_W;
  localparam int MeanW  = wms_pkg::MEAN_W;
  localparam int StdW   = wms_pkg::STD_W;
  localparam int FillW  = wms_pkg::FILL_W;
  localparam int CntMax = wms_pkg::cnt_max(WINDOW_MAX);
  localparam int CntW   = $clog2(CntMax + 1);
  localparam int LogW   = $clog2(CntMax);
  localparam int SumW   = Sw + LogW;
  localparam int SqW    = 2 * Sw - 1 + LogW;
  localparam int XsqW   = 2 * Sw;
  localparam int DiffFl = 2 * Sw + 2 * LogW - 1;
  localparam int DiffW  = (DiffFl > 64) ? 64 : DiffFl;
  localparam int DiffWE = DiffW + (DiffW % 2);
  localparam int RtW    = DiffWE / 2;
  localparam int DivW   = (SumW > RtW) ? SumW : RtW;
  localparam int HalfW  = (SumW + 1) / 2;
  localparam int HiW    = SumW - HalfW;
  localparam int PtrW   = $clog2(WINDOW_MAX);
  localparam int AddrW  = ((PtrW > CntW) ? PtrW : CntW) + 1;
  localparam int ItrW   = $clog2(RtW + 1);
  localparam int ExtW   = ((DivW + 1) > MeanW) ? DivW + 1 : MeanW;

  wms_pkg::back_state_e state_q, state_d;

  // item taken from the queue
  wms_pkg::item_ctrl_t q_ctrl, ctrl_q;
  logic signed [Sw-1:0] q_sample, x_q;

  // ring and running state
  logic signed [Sw-1:0]   ring_q [WINDOW_MAX];
  logic signed [Sw-1:0]   rd_q, y_eff;
  logic [PtrW-1:0]        wp_q, rd_addr;
  logic [AddrW-1:0]       wp_ext, held_ext, addr_w;
  logic [CntW-1:0]        held_q;
  logic signed [SumW-1:0] sum_q;
  logic [SqW-1:0]         sq_q;
  logic                   drop_q, drop_now;

  // products
  logic signed [XsqW-1:0]   xsq_full, ysq_full;
  logic [XsqW-1:0]          xsq_q, ysq_q;
  logic [CntW+SqW-1:0]      cs_full;
  logic [SumW-1:0]          mag;
  logic [SumW+HalfW-1:0]    pp_lo_full;
  logic [SumW+HiW-1:0]      pp_hi_full;
  logic [2*SumW-1:0]        pp_hi_sh;
  logic [DiffW-1:0]         cs_q, pp_q, diff_now;
  logic                     neg_q;

  // square root
  logic [DiffWE-1:0] rem_q, root_q, bit_q, trial;
  logic [ItrW-1:0]   itr_q;

  // divider and results
  logic              div_start, div_busy;
  logic [DivW-1:0]   div_dividend, div_quot;
  logic [ExtW-1:0]   q_ext, mean_full;
  logic [MeanW-1:0]  mean_res_q;
  logic              out_load, out_valid_q;
  logic [MeanW-1:0]  out_mean_q;
  logic [StdW-1:0]   out_std_q;
  logic [FillW-1:0]  out_fill_q;

  assign q_ctrl   = q_data_i[ItemW-1:Sw];
  assign q_sample = q_data_i[Sw-1:0];

  // oldest held entry sits held_q places behind the write pointer
  always_comb begin
    wp_ext   = AddrW'(wp_q);
    held_ext = AddrW'(held_q);
    if (wp_ext >= held_ext) begin
      addr_w = wp_ext - held_ext;
    end else begin
      addr_w = wp_ext + AddrW'(WINDOW_MAX) - held_ext;
    end
    rd_addr  = addr_w[PtrW-1:0];
    drop_now = (CfgW'(held_q) >= ctrl_q.win);
    y_eff    = drop_q ? rd_q : '0;
  end

  assign xsq_full   = x_q * x_q;
  assign ysq_full   = rd_q * rd_q;
  assign cs_full    = held_q * sq_q;
  assign mag        = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign pp_lo_full = mag * mag[HalfW-1:0];
  assign pp_hi_full = mag * mag[SumW-1:HalfW];
  assign pp_hi_sh   = {pp_hi_full, {HalfW{1'b0}}};
  assign diff_now   = cs_q - (pp_hi_sh[DiffW-1:0] + pp_q);
  assign trial      = root_q + bit_q;

  assign q_ext     = ExtW'(div_quot);
  assign mean_full = neg_q ? -q_ext : q_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wms_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    q_pop_o      = 1'b0;
    div_start    = 1'b0;
    div_dividend = DivW'(mag);
    out_load     = 1'b0;
    case (state_q)
      wms_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = wms_pkg::BK_READ;
        end
      end
      wms_pkg::BK_READ:   state_d = wms_pkg::BK_SQUARE;
      wms_pkg::BK_SQUARE: state_d = wms_pkg::BK_UPDATE;
      wms_pkg::BK_UPDATE: state_d = wms_pkg::BK_PROD_LO;
      wms_pkg::BK_PROD_LO: begin
        // mean divide runs alongside the root
        div_start = 1'b1;
        state_d   = wms_pkg::BK_PROD_HI;
      end
      wms_pkg::BK_PROD_HI: state_d = wms_pkg::BK_ROOT;
      wms_pkg::BK_ROOT: begin
        if (itr_q == '0 && !div_busy) begin
          div_start    = 1'b1;
          div_dividend = DivW'(root_q[RtW-1:0]);
          state_d      = wms_pkg::BK_DIV_STD;
        end
      end
      wms_pkg::BK_DIV_STD: begin
        if (!div_busy && (!out_valid_q || m_ready_i)) begin
          out_load = 1'b1;
          state_d  = wms_pkg::BK_IDLE;
        end
      end
      default: state_d = wms_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      held_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      itr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o && q_ctrl.start) begin
        wp_q   <= '0;
        held_q <= '0;
        sum_q  <= '0;
        sq_q   <= '0;
      end else if (state_q == wms_pkg::BK_UPDATE) begin
        wp_q  <= (wp_q == PtrW'(WINDOW_MAX - 1)) ? '0 : wp_q + PtrW'(1);
        sum_q <= sum_q - SumW'(y_eff) + SumW'(x_q);
        sq_q  <= sq_q - SqW'(ysq_q) + SqW'(xsq_q);
        if (!drop_q) begin
          held_q <= held_q + CntW'(1);
        end
      end
      if (state_q == wms_pkg::BK_PROD_HI) begin
        itr_q <= ItrW'(RtW);
      end else if (state_q == wms_pkg::BK_ROOT && itr_q != '0) begin
        itr_q <= itr_q - ItrW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sample ring
  always_ff @(posedge clk_i) begin
    if (state_q == wms_pkg::BK_UPDATE) begin
      ring_q[wp_q] <= x_q;
    end
    if (state_q == wms_pkg::BK_READ) begin
      rd_q <= ring_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      wms_pkg::BK_IDLE: begin
        if (q_pop_o) begin
          ctrl_q <= q_ctrl;
          x_q    <= q_sample;
        end
      end
      wms_pkg::BK_READ: begin
        drop_q <= drop_now;
        xsq_q  <= xsq_full;
      end
      wms_pkg::BK_SQUARE: begin
        ysq_q <= drop_q ? ysq_full : '0;
      end
      wms_pkg::BK_PROD_LO: begin
        cs_q  <= cs_full[DiffW-1:0];
        pp_q  <= DiffW'(pp_lo_full);
        neg_q <= sum_q[SumW-1];
      end
      wms_pkg::BK_PROD_HI: begin
        rem_q  <= DiffWE'(diff_now);
        root_q <= '0;
        bit_q  <= {2'b01, {(DiffWE-2){1'b0}}};
      end
      wms_pkg::BK_ROOT: begin
        if (itr_q != '0) begin
          if (rem_q >= trial) begin
            rem_q  <= rem_q - trial;
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else if (div_start) begin
          mean_res_q <= mean_full[MeanW-1:0];
        end
      end
      wms_pkg::BK_DIV_STD: begin
        if (out_load) begin
          out_mean_q <= mean_res_q;
          out_std_q  <= q_ext[StdW-1:0];
          out_fill_q <= FillW'(held_q);
        end
      end
      default: ;
    endcase
  end

  wms_div #(
    .DIVIDEND_W (DivW),
    .DIVISOR_W  (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (held_q),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  assign m_valid_o = out_valid_q;
  assign mean_o    = out_mean_q;
  assign std_o     = out_std_q;
  assign fill_o    = out_fill_q;

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntW'(CntMax))
    else $error("held count beyond window capacity");

  a_held_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == wms_pkg::BK_UPDATE |=> held_q != '0)
    else $error("empty window after update");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wms_pkg::BK_ROOT && itr_q == '0) |-> rem_q <= (root_q << 1))
    else $error("square root remainder too large");

endmodule

// ===== src/windowed_mean_std_core.sv =====
// Top level of the windowed mean and standard deviation block.
//
// Each input item carries one signed sample (Q8.8 at the default width); each
// accepted item gives exactly one result item holding the mean (truncated
// toward zero), the population standard deviation (floored) and the number of
// samples used, taken over the last window_length samples of the current
// series, or over all of them while the window is still filling. Setting
// tuser on an item starts a new series and discards the history first. The
// window register is 7 bits; 0 behaves as 1 and values above WINDOW_MAX
// behave as WINDOW_MAX. Write it only between series while the block is idle;
// a smaller window takes hold at the next series start, a larger one lets the
// window grow into it. One item at a time goes through the back end; its time
// there is set by the bit-serial square root followed by the standard-deviation
// divide on the shared one-bit-per-cycle divider; the mean divide overlaps the
// root. A two-item queue in front and a result register behind let the input
// side keep taking items while a result waits. No clearing pass is needed
// after reset: ring entries are only used after being written.
module windowed_mean_std_core #(
  parameter int WINDOW_MAX   = wms_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = wms_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // window_length register
  input  logic                                cfg_we_i,
  input  logic [wms_pkg::CFG_W-1:0]           cfg_wdata_i,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // sample
  input  logic                                s_axis_tuser,  // start_series
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [wms_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // mean, std_dev, fill
);

  localparam int ItemW = $bits(wms_pkg::item_ctrl_t) + SAMPLE_WIDTH;
  localparam int OutW  = wms_pkg::OUT_TDATA_W;

  logic             push, q_full, q_valid, q_pop;
  logic [ItemW-1:0] push_data, q_data;

  logic [wms_pkg::MEAN_W-1:0] mean;
  logic [wms_pkg::STD_W-1:0]  std_dev;
  logic [wms_pkg::FILL_W-1:0] fill;

  // front: window register, clamping, tagging
  wms_front #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_sample_i (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .in_start_i  (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decouples accepting from computing
  wms_fifo #(
    .DATA_W (ItemW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  // back: ring, sums, root, divides, result register
  wms_back #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .mean_o    (mean),
    .std_o     (std_dev),
    .fill_o    (fill)
  );

  // mean in the low bits, then std_dev, then fill, zero padded
  assign m_axis_tdata = OutW'({fill, std_dev, mean});

endmodule
